// File: hdl/i2cms_pkg.sv
// Shared types and constants for the I2C master script engine.
package i2cms_pkg;

    // Operations of an input transaction
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Register selects
    localparam logic [2:0] REG_IADR = 3'd0;
    localparam logic [2:0] REG_IFDR = 3'd1;
    localparam logic [2:0] REG_I2CR = 3'd2;
    localparam logic [2:0] REG_I2SR = 3'd3;
    localparam logic [2:0] REG_I2DR = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_HOLD_START = 3'd0;
    localparam logic [2:0] CFG_CLOCK_LOW  = 3'd1;
    localparam logic [2:0] CFG_CLOCK_HIGH = 3'd2;
    localparam logic [2:0] CFG_DATA_HOLD  = 3'd3;
    localparam logic [2:0] CFG_STOP_SETUP = 3'd4;
    localparam logic [2:0] CFG_BUS_FREE   = 3'd5;
    localparam logic [2:0] CFG_TIMEOUT    = 3'd6;

    // Control and status bit positions
    localparam int CR_IEN  = 7;
    localparam int CR_MSTA = 5;
    localparam int CR_TXAK = 3;
    localparam int SR_IBB  = 5;
    localparam int SR_IAL  = 4;
    localparam int SR_IIF  = 1;
    localparam int SR_RXAK = 0;

    localparam logic [7:0] CTRL_STORE_MASK = 8'hfc;
    localparam logic [7:0] IADR_MASK       = 8'hfe;
    localparam logic [5:0] IFDR_MASK       = 6'h3f;
    localparam logic [7:0] SR_W0C_MASK     = 8'h12;

    // Master modes
    localparam logic [1:0] M_IDLE  = 2'd0;
    localparam logic [1:0] M_READ  = 2'd1;
    localparam logic [1:0] M_WRITE = 2'd2;

    // Micro-instruction opcodes (U_NONE marks an absent slot)
    typedef logic [3:0] t_uop;
    localparam t_uop U_NONE    = 4'h0;
    localparam t_uop U_SDA_LOW = 4'h1;
    localparam t_uop U_SDA_REL = 4'h2;
    localparam t_uop U_SCL_LOW = 4'h3;
    localparam t_uop U_SCL_REL = 4'h4;
    localparam t_uop U_ARB     = 4'h5;
    localparam t_uop U_WAIT    = 4'h6;
    localparam t_uop U_SYNC    = 4'h7;
    localparam t_uop U_END     = 4'h8;
    localparam t_uop U_IRQ     = 4'h9;
    localparam t_uop U_ACKCHK  = 4'ha;
    localparam t_uop U_BIT     = 4'hb;
    localparam t_uop U_ACKIN   = 4'hc;
    localparam t_uop U_RXDONE  = 4'hd;
    localparam t_uop U_BUSFREE = 4'he;

    localparam logic [23:0] START_SETTLE_TICKS = 24'd50;

    typedef struct packed {
        logic [1:0] operation;
        logic [2:0] reg_select;
        logic [7:0] write_data;
        logic       sda_in;
        logic       scl_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       sda_drive_low;
        logic       scl_drive_low;
        logic       irq_n;
        logic       engine_fault;
    } t_out_item;

    typedef enum logic [1:0] {
        GK_START    = 2'd0,
        GK_STOP     = 2'd1,
        GK_SEND     = 2'd2,
        GK_RECV_ACK = 2'd3
    } t_gen_kind;

    typedef struct packed {
        logic       go;
        t_gen_kind  kind;
        logic [7:0] tx_byte;
        logic       rx_after;
        logic       from_idle;
        logic       txak;
    } t_gen_cmd;

    typedef struct packed {
        logic        valid;
        t_uop        op;
        logic [23:0] arg;
    } t_gen_emit;

    typedef struct packed {
        logic [23:0] hold_start;
        logic [23:0] clock_low;
        logic [23:0] clock_high;
        logic [23:0] data_hold;
        logic [23:0] stop_setup;
        logic [23:0] bus_free;
    } t_timing;

endpackage

// File: hdl/i2cms_gen.sv
// Script generator: expands start, stop, send and receive into micro-instructions.
module i2cms_gen import i2cms_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_gen_cmd  i_cmd,
    input  t_timing   i_tim,
    output t_gen_emit o_emit,
    output logic      o_busy
);

    typedef enum logic [8:0] {
        G_IDLE   = 9'b000000001,
        G_START  = 9'b000000010,
        G_STOP   = 9'b000000100,
        G_TX     = 9'b000001000,
        G_ACKCHK = 9'b000010000,
        G_NAK    = 9'b000100000,
        G_RXPRE  = 9'b001000000,
        G_RX     = 9'b010000000,
        G_RXEND  = 9'b100000000
    } t_gph;

    t_gph        r_ph, n_ph;
    logic [3:0]  r_step, n_step;
    logic [3:0]  r_cnt, n_cnt;
    logic [7:0]  r_byte;
    logic        r_rx, r_idle, r_txak;
    logic [23:0] low_part;
    t_uop        pre_op, mid_op, e_op;
    logic [23:0] e_arg;
    logic        tx_bit;

    assign low_part = (i_tim.clock_low > i_tim.data_hold) ?
                      (i_tim.clock_low - i_tim.data_hold) : 24'd0;
    assign tx_bit   = r_byte[~r_cnt[2:0]];

    // SDA setup before the pulse and the action while SCL is high
    always_comb begin
        pre_op = U_NONE;
        mid_op = U_NONE;
        case (r_ph)
            G_TX: begin
                if (r_cnt == 4'd8) begin
                    pre_op = U_SDA_REL;
                    mid_op = U_ACKIN;
                end else begin
                    pre_op = tx_bit ? U_SDA_REL : U_SDA_LOW;
                    mid_op = tx_bit ? U_ARB : U_NONE;
                end
            end
            G_NAK: begin
                pre_op = r_txak ? U_SDA_REL : U_SDA_LOW;
                mid_op = r_txak ? U_ARB : U_NONE;
            end
            G_RX: mid_op = U_BIT;
            default: ;
        endcase
    end

    always_comb begin
        n_ph   = r_ph;
        n_step = r_step + 4'd1;
        n_cnt  = r_cnt;
        e_op   = U_NONE;
        e_arg  = 24'd0;
        case (r_ph)
            G_IDLE: begin
                n_step = 4'd0;
                n_cnt  = 4'd0;
                if (i_cmd.go) begin
                    case (i_cmd.kind)
                        GK_START: n_ph = G_START;
                        GK_STOP:  n_ph = G_STOP;
                        GK_SEND:  n_ph = G_TX;
                        default:  n_ph = G_NAK;
                    endcase
                end
            end
            G_START: begin
                case (r_step)
                    4'd0: e_op = r_idle ? U_BUSFREE : U_SDA_REL;
                    4'd1: begin
                        e_op  = U_WAIT;
                        e_arg = r_idle ? START_SETTLE_TICKS : low_part;
                        if (r_idle) n_step = 4'd5;
                    end
                    4'd2: e_op = U_SCL_REL;
                    4'd3: e_op = U_SYNC;
                    4'd4: begin e_op = U_WAIT; e_arg = i_tim.clock_high; end
                    4'd5: e_op = U_ARB;
                    4'd6: e_op = U_SDA_LOW;
                    4'd7: begin e_op = U_WAIT; e_arg = i_tim.hold_start; end
                    4'd8: e_op = U_SCL_LOW;
                    default: begin
                        e_op  = U_WAIT;
                        e_arg = i_tim.data_hold;
                        n_ph  = G_IDLE;
                    end
                endcase
            end
            G_STOP: begin
                case (r_step)
                    4'd0: e_op = U_SDA_LOW;
                    4'd1: begin e_op = U_WAIT; e_arg = low_part; end
                    4'd2: e_op = U_SCL_REL;
                    4'd3: e_op = U_SYNC;
                    4'd4: begin e_op = U_WAIT; e_arg = i_tim.stop_setup; end
                    4'd5: e_op = U_SDA_REL;
                    default: begin
                        e_op  = U_WAIT;
                        e_arg = i_tim.bus_free;
                        n_ph  = G_IDLE;
                    end
                endcase
            end
            G_TX, G_NAK, G_RX: begin
                // one SCL pulse, eight slots
                case (r_step)
                    4'd0: e_op = pre_op;
                    4'd1: begin e_op = U_WAIT; e_arg = low_part; end
                    4'd2: e_op = U_SCL_REL;
                    4'd3: e_op = U_SYNC;
                    4'd4: begin e_op = U_WAIT; e_arg = i_tim.clock_high; end
                    4'd5: e_op = mid_op;
                    4'd6: e_op = U_SCL_LOW;
                    default: begin
                        e_op   = U_WAIT;
                        e_arg  = i_tim.data_hold;
                        n_step = 4'd0;
                        n_cnt  = r_cnt + 4'd1;
                        if (r_ph == G_TX && r_cnt == 4'd8) begin
                            n_ph = G_ACKCHK;
                        end else if (r_ph == G_NAK) begin
                            n_ph = G_RXPRE;
                        end else if (r_ph == G_RX && r_cnt == 4'd7) begin
                            n_ph = G_RXEND;
                        end
                    end
                endcase
            end
            G_ACKCHK: begin
                e_op = U_ACKCHK;
                n_ph = r_rx ? G_RXPRE : G_IDLE;
            end
            G_RXPRE: begin
                e_op   = U_SDA_REL;
                n_ph   = G_RX;
                n_step = 4'd0;
                n_cnt  = 4'd0;
            end
            G_RXEND: begin
                if (r_step == 4'd0) begin
                    e_op = U_RXDONE;
                end else begin
                    e_op = U_IRQ;
                    n_ph = G_IDLE;
                end
            end
            default: n_ph = G_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= G_IDLE;
            r_step <= 4'd0;
            r_cnt  <= 4'd0;
        end else begin
            r_ph   <= n_ph;
            r_step <= n_step;
            r_cnt  <= n_cnt;
        end
        if (r_ph == G_IDLE && i_cmd.go) begin
            r_byte <= i_cmd.tx_byte;
            r_rx   <= i_cmd.rx_after;
            r_idle <= i_cmd.from_idle;
            r_txak <= i_cmd.txak;
        end
    end

    assign o_emit.valid = (e_op != U_NONE);
    assign o_emit.op    = e_op;
    assign o_emit.arg   = e_arg;
    assign o_busy       = (r_ph != G_IDLE);

endmodule

// File: hdl/i2c_master_script_engine_core.sv
// Top level of the I2C master script engine: registers, code store and executor.
//
// One transaction on the input channel is a time tick, a register read or a
// register write; each yields exactly one result transaction carrying the read
// byte, the SDA/SCL pull-down drives, the interrupt line and the fault flag.
// Work per transaction is sequential: capture; the tick, bus monitor, stretch
// check and register access; generation into the code store (a byte send writes
// 65-73 micro-instructions, a receive 59-67, a start 7 or 10, a stop 7; a pulse
// with no action while SCL is high still spends a generator slot on it); a
// registered read of the code store, then decode, per executed micro-instruction;
// then posting of the result. A plain tick with the engine waiting goes through
// capture, the tick step, a fetch check and the post only. The code store has a
// write port and a separate registered read port; generation and execution do
// not overlap but run one after the other. The next transaction is accepted
// while the previous result still waits on the output register.
// The code store needs no clearing: only entries below the fill count are read.
module i2c_master_script_engine_core import i2cms_pkg::*; #(
    parameter int CODE_DEPTH = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    localparam int AW = $clog2(CODE_DEPTH);
    localparam int CW = $clog2(CODE_DEPTH + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PRE   = 6'b000010,
        S_GEN   = 6'b000100,
        S_FETCH = 6'b001000,
        S_EXEC  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state      r_st, n_st;
    t_in_item    r_in, n_in;
    t_timing     r_tim;
    logic [31:0] r_timeout;

    // bus-visible registers
    logic [7:0]  r_sa, n_sa;
    logic [5:0]  r_fd, n_fd;
    logic [7:0]  r_ctrl, n_ctrl;
    logic [7:0]  r_stat, n_stat;
    logic [7:0]  r_data, n_data;
    logic [1:0]  r_mode, n_mode;

    // engine state
    logic [CW-1:0] r_ptr, n_ptr;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [7:0]    r_rx, n_rx;
    logic          r_ack, n_ack;
    logic          r_active, n_active;
    logic [23:0]   r_delay, n_delay;
    logic          r_stretch, n_stretch;
    logic [31:0]   r_scnt, n_scnt;
    logic          r_bfwait, n_bfwait;
    logic          r_sda_prev, n_sda_prev;
    logic [1:0]    r_drive, n_drive;
    logic          r_fault, n_fault;
    logic [7:0]    r_rd, n_rd;
    t_out_item     r_out, n_out;
    logic          r_out_valid, n_out_valid;

    // code store
    logic [27:0]   code_store [CODE_DEPTH];
    logic [27:0]   r_rdata;
    logic          mem_we, mem_re;
    logic [27:0]   mem_wdata;

    // generator link
    t_gen_cmd      gcmd;
    t_gen_emit     gemit;
    logic          gbusy;

    // scratch
    logic          tick, do_clear, do_launch, go;
    logic [31:0]   scnt_inc;
    t_uop          x_op;
    logic [23:0]   x_arg;
    logic [7:0]    wd;

    i2cms_gen u_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (gcmd),
        .i_tim   (r_tim),
        .o_emit  (gemit),
        .o_busy  (gbusy)
    );

    assign o_in_ready  = (r_st == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign tick      = (r_in.operation == OP_TICK);
    assign wd        = r_in.write_data;
    assign scnt_inc  = (r_scnt != 32'hffff_ffff) ? (r_scnt + 32'd1) : r_scnt;
    assign x_op      = r_rdata[27:24];
    assign x_arg     = r_rdata[23:0];
    assign mem_wdata = {gemit.op, gemit.arg};

    always_comb begin
        n_st        = r_st;
        n_in        = r_in;
        n_sa        = r_sa;
        n_fd        = r_fd;
        n_ctrl      = r_ctrl;
        n_stat      = r_stat;
        n_data      = r_data;
        n_mode      = r_mode;
        n_ptr       = r_ptr;
        n_cnt       = r_cnt;
        n_rx        = r_rx;
        n_ack       = r_ack;
        n_active    = r_active;
        n_delay     = r_delay;
        n_stretch   = r_stretch;
        n_scnt      = r_scnt;
        n_bfwait    = r_bfwait;
        n_sda_prev  = r_sda_prev;
        n_drive     = r_drive;
        n_fault     = r_fault;
        n_rd        = r_rd;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        gcmd        = '0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        do_clear    = 1'b0;
        do_launch   = 1'b0;
        go          = 1'b1;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_st)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in = i_in;
                    n_st = S_PRE;
                end
            end

            S_PRE: begin
                if (tick && r_delay != 24'd0) begin
                    n_delay = r_delay - 24'd1;
                end
                // bus monitor: SDA edge while SCL high
                if (r_in.scl_in && (r_in.sda_in != r_sda_prev)) begin
                    if (!r_in.sda_in) begin
                        n_stat[SR_IBB] = 1'b1;
                    end else begin
                        n_stat[SR_IBB] = 1'b0;
                        if (r_bfwait) begin
                            n_bfwait = 1'b0;
                            n_delay  = r_tim.bus_free;
                        end
                    end
                end
                // clock stretch wait and time-out
                if (r_stretch) begin
                    if (r_in.scl_in) begin
                        n_stretch = 1'b0;
                    end else if (tick) begin
                        n_scnt = scnt_inc;
                        if (scnt_inc >= r_timeout) begin
                            n_stretch = 1'b0;
                            n_active  = 1'b0;
                        end
                    end
                end
                n_sda_prev = r_in.sda_in;
                n_rd       = 8'd0;

                if (r_in.operation == OP_READ) begin
                    case (r_in.reg_select)
                        REG_IADR: n_rd = r_sa;
                        REG_IFDR: n_rd = {2'b00, r_fd};
                        REG_I2CR: n_rd = r_ctrl;
                        REG_I2SR: n_rd = n_stat;
                        REG_I2DR: begin
                            n_rd = r_data;
                            // read mode: acknowledge and fetch the next byte
                            if (r_mode == M_READ) begin
                                do_clear     = 1'b1;
                                do_launch    = 1'b1;
                                gcmd.go      = 1'b1;
                                gcmd.kind    = GK_RECV_ACK;
                                gcmd.txak    = r_ctrl[CR_TXAK];
                            end
                        end
                        default: n_rd = 8'd0;
                    endcase
                end else if (r_in.operation == OP_WRITE) begin
                    case (r_in.reg_select)
                        REG_IADR: n_sa = wd & IADR_MASK;
                        REG_IFDR: n_fd = wd[5:0] & IFDR_MASK;
                        REG_I2CR: begin
                            if (r_ctrl[CR_IEN]) begin
                                if (wd[CR_MSTA] && !r_ctrl[CR_MSTA]) begin
                                    // start or repeated start, waits for a data write
                                    do_clear       = 1'b1;
                                    gcmd.go        = 1'b1;
                                    gcmd.kind      = GK_START;
                                    gcmd.from_idle = (r_mode == M_IDLE);
                                end else if (!wd[CR_MSTA] && r_ctrl[CR_MSTA]) begin
                                    do_clear  = 1'b1;
                                    do_launch = 1'b1;
                                    gcmd.go   = 1'b1;
                                    gcmd.kind = GK_STOP;
                                    n_mode    = M_IDLE;
                                end
                            end
                            n_ctrl = wd & CTRL_STORE_MASK;
                        end
                        REG_I2SR: n_stat = n_stat & ~(~wd & SR_W0C_MASK);
                        REG_I2DR: begin
                            if (r_ctrl[CR_MSTA] && r_mode == M_IDLE) begin
                                // address byte appended after the start sequence
                                do_launch     = 1'b1;
                                gcmd.go       = 1'b1;
                                gcmd.kind     = GK_SEND;
                                gcmd.tx_byte  = wd;
                                gcmd.rx_after = wd[0];
                                n_mode        = wd[0] ? M_READ : M_WRITE;
                            end else if (r_mode == M_WRITE) begin
                                do_clear     = 1'b1;
                                do_launch    = 1'b1;
                                gcmd.go      = 1'b1;
                                gcmd.kind    = GK_SEND;
                                gcmd.tx_byte = wd;
                            end
                        end
                        default: ;
                    endcase
                end

                if (do_clear) begin
                    n_bfwait  = 1'b0;
                    n_ptr     = '0;
                    n_cnt     = '0;
                    n_rx      = 8'd0;
                    n_ack     = 1'b0;
                    n_delay   = 24'd0;
                    n_active  = 1'b0;
                    n_stretch = 1'b0;
                    n_scnt    = 32'd0;
                    n_fault   = 1'b0;
                end
                if (do_launch && !n_active) begin
                    n_active = 1'b1;
                    n_delay  = 24'd0;
                end
                n_st = gcmd.go ? S_GEN : S_FETCH;
            end

            S_GEN: begin
                // append instructions; a full store drops them and flags a fault
                if (gemit.valid) begin
                    if (r_cnt < CW'(CODE_DEPTH)) begin
                        mem_we = 1'b1;
                        n_cnt  = r_cnt + CW'(1);
                    end else begin
                        n_fault = 1'b1;
                    end
                end
                if (!gbusy) begin
                    n_st = S_FETCH;
                end
            end

            S_FETCH: begin
                if (!r_active || r_delay != 24'd0 || r_stretch || r_bfwait) begin
                    n_st = S_OUT;
                end else if (r_ptr >= CW'(CODE_DEPTH)) begin
                    n_fault  = 1'b1;
                    n_active = 1'b0;
                    n_st     = S_OUT;
                end else if (r_ptr >= r_cnt) begin
                    n_active = 1'b0;
                    n_st     = S_OUT;
                end else begin
                    mem_re = 1'b1;
                    n_st   = S_EXEC;
                end
            end

            S_EXEC: begin
                n_ptr = r_ptr + CW'(1);
                case (x_op)
                    U_SDA_LOW: n_drive[0] = 1'b1;
                    U_SDA_REL: n_drive[0] = 1'b0;
                    U_SCL_LOW: n_drive[1] = 1'b1;
                    U_SCL_REL: n_drive[1] = 1'b0;
                    U_ARB: begin
                        // lost arbitration: someone else holds SDA low
                        if (!r_in.sda_in) begin
                            n_stat[SR_IAL] = 1'b1;
                            n_mode         = M_IDLE;
                            n_active       = 1'b0;
                            go             = 1'b0;
                        end
                    end
                    U_WAIT: begin
                        n_delay = x_arg;
                        go      = 1'b0;
                    end
                    U_SYNC: begin
                        if (!r_in.scl_in) begin
                            n_stretch = 1'b1;
                            n_scnt    = 32'd0;
                            go        = 1'b0;
                        end
                    end
                    U_END: begin
                        n_active = 1'b0;
                        go       = 1'b0;
                    end
                    U_IRQ: begin
                        n_stat[SR_IIF] = 1'b1;
                        n_active       = 1'b0;
                        go             = 1'b0;
                    end
                    U_ACKCHK: begin
                        if (!r_ack) begin
                            n_stat[SR_RXAK] = 1'b1;
                            n_active        = 1'b0;
                            go              = 1'b0;
                        end else begin
                            n_stat[SR_RXAK] = 1'b0;
                        end
                    end
                    U_BIT:    n_rx  = {r_rx[6:0], r_in.sda_in};
                    U_ACKIN:  n_ack = ~r_in.sda_in;
                    U_RXDONE: n_data = r_rx;
                    U_BUSFREE: begin
                        if (r_stat[SR_IBB]) begin
                            n_bfwait = 1'b1;
                            go       = 1'b0;
                        end
                    end
                    default: begin
                        n_fault  = 1'b1;
                        n_active = 1'b0;
                        go       = 1'b0;
                    end
                endcase
                n_st = go ? S_FETCH : S_OUT;
            end

            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.read_data     = r_rd;
                    n_out.sda_drive_low = r_drive[0];
                    n_out.scl_drive_low = r_drive[1];
                    n_out.irq_n         = ~r_stat[SR_IIF];
                    n_out.engine_fault  = r_fault;
                    n_out_valid         = 1'b1;
                    n_st                = S_IDLE;
                end
            end

            default: n_st = S_IDLE;
        endcase
    end

    // code store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            code_store[r_cnt[AW-1:0]] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= code_store[r_ptr[AW-1:0]];
        end
    end

    // timing configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tim.hold_start <= 24'd4000;
            r_tim.clock_low  <= 24'd4700;
            r_tim.clock_high <= 24'd4000;
            r_tim.data_hold  <= 24'd1725;
            r_tim.stop_setup <= 24'd4000;
            r_tim.bus_free   <= 24'd4700;
            r_timeout        <= 32'd200000000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HOLD_START: r_tim.hold_start <= i_cfg_data[23:0];
                CFG_CLOCK_LOW:  r_tim.clock_low  <= i_cfg_data[23:0];
                CFG_CLOCK_HIGH: r_tim.clock_high <= i_cfg_data[23:0];
                CFG_DATA_HOLD:  r_tim.data_hold  <= i_cfg_data[23:0];
                CFG_STOP_SETUP: r_tim.stop_setup <= i_cfg_data[23:0];
                CFG_BUS_FREE:   r_tim.bus_free   <= i_cfg_data[23:0];
                CFG_TIMEOUT:    r_timeout        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= S_IDLE;
            r_sa        <= 8'd0;
            r_fd        <= 6'd0;
            r_ctrl      <= 8'd0;
            r_stat      <= 8'd0;
            r_data      <= 8'd0;
            r_mode      <= M_IDLE;
            r_ptr       <= '0;
            r_cnt       <= '0;
            r_rx        <= 8'd0;
            r_ack       <= 1'b0;
            r_active    <= 1'b0;
            r_delay     <= 24'd0;
            r_stretch   <= 1'b0;
            r_scnt      <= 32'd0;
            r_bfwait    <= 1'b0;
            r_sda_prev  <= 1'b1;
            r_drive     <= 2'b00;
            r_fault     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_st        <= n_st;
            r_sa        <= n_sa;
            r_fd        <= n_fd;
            r_ctrl      <= n_ctrl;
            r_stat      <= n_stat;
            r_data      <= n_data;
            r_mode      <= n_mode;
            r_ptr       <= n_ptr;
            r_cnt       <= n_cnt;
            r_rx        <= n_rx;
            r_ack       <= n_ack;
            r_active    <= n_active;
            r_delay     <= n_delay;
            r_stretch   <= n_stretch;
            r_scnt      <= n_scnt;
            r_bfwait    <= n_bfwait;
            r_sda_prev  <= n_sda_prev;
            r_drive     <= n_drive;
            r_fault     <= n_fault;
            r_out_valid <= n_out_valid;
        end
        r_in  <= n_in;
        r_rd  <= n_rd;
        r_out <= n_out;
    end

endmodule

// File: test/tb.sv
// Testbench for the I2C master script engine: predictor, stimulus and result checking.
`timescale 1ns / 100ps

module tb;
    import i2cms_pkg::*;

    localparam int CODE_DEPTH = 512;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;

    i2c_master_script_engine_core #(.CODE_DEPTH(CODE_DEPTH)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Predictor state: a software copy of the bus controller
    // ---------------------------------------------------------------
    logic [23:0] t_hold_start, t_clock_low, t_clock_high, t_data_hold;
    logic [23:0] t_stop_setup, t_bus_free;
    logic [31:0] t_timeout;

    logic [7:0]  p_iadr, p_i2cr, p_i2sr, p_i2dr;
    logic [5:0]  p_ifdr;
    logic [1:0]  p_mode;
    logic [27:0] p_code [CODE_DEPTH];
    int unsigned p_ip, p_count;
    logic [7:0]  p_rx;
    logic        p_ack, p_active, p_stretch, p_busfree_wait, p_sda_prev, p_fault;
    logic [23:0] p_delay;
    logic [31:0] p_stretch_cnt;
    logic [1:0]  p_drive;

    t_out_item   expected_q[$];
    int          mismatches = 0;
    int          bus_sda = 1;       // modelled line levels used by stimulus
    int          bus_scl = 1;

    // transaction count and receiver hold-off, shared by tests and receiver
    int sent = 0;
    int hold_cycles = 0;
    int stall_phase = 0;

    task automatic emit(input t_uop op, input logic [23:0] arg);
        if (p_count < CODE_DEPTH) begin
            p_code[p_count] = {op, arg};
            p_count++;
        end else begin
            p_fault = 1'b1;
        end
    endtask

    function automatic logic [23:0] low_part();
        return (t_clock_low > t_data_hold) ? t_clock_low - t_data_hold : 24'd0;
    endfunction

    task automatic engine_clear();
        p_busfree_wait = 0; p_ip = 0; p_count = 0; p_rx = '0; p_ack = 0;
        p_delay = '0; p_active = 0; p_stretch = 0; p_stretch_cnt = '0; p_fault = 0;
    endtask

    // one SCL pulse with optional SDA setup before and action while high
    task automatic emit_pulse(input t_uop pre, input t_uop mid);
        if (pre != U_NONE) emit(pre, '0);
        emit(U_WAIT, low_part());
        emit(U_SCL_REL, '0);
        emit(U_SYNC, '0);
        emit(U_WAIT, t_clock_high);
        if (mid != U_NONE) emit(mid, '0);
        emit(U_SCL_LOW, '0);
        emit(U_WAIT, t_data_hold);
    endtask

    task automatic emit_start();
        if (p_mode != M_IDLE) begin
            emit(U_SDA_REL, '0);
            emit(U_WAIT, low_part());
            emit(U_SCL_REL, '0);
            emit(U_SYNC, '0);
            emit(U_WAIT, t_clock_high);
        end else begin
            emit(U_BUSFREE, '0);
            emit(U_WAIT, START_SETTLE_TICKS);
        end
        emit(U_ARB, '0);
        emit(U_SDA_LOW, '0);
        emit(U_WAIT, t_hold_start);
        emit(U_SCL_LOW, '0);
        emit(U_WAIT, t_data_hold);
    endtask

    task automatic emit_stop();
        emit(U_SDA_LOW, '0);
        emit(U_WAIT, low_part());
        emit(U_SCL_REL, '0);
        emit(U_SYNC, '0);
        emit(U_WAIT, t_stop_setup);
        emit(U_SDA_REL, '0);
        emit(U_WAIT, t_bus_free);
    endtask

    task automatic emit_send(input logic [7:0] b);
        for (int k = 7; k >= 0; k--)
            emit_pulse(b[k] ? U_SDA_REL : U_SDA_LOW, b[k] ? U_ARB : U_NONE);
        emit_pulse(U_SDA_REL, U_ACKIN);
        emit(U_ACKCHK, '0);
    endtask

    task automatic emit_receive();
        emit(U_SDA_REL, '0);
        for (int k = 0; k < 8; k++) emit_pulse(U_NONE, U_BIT);
        emit(U_RXDONE, '0);
        emit(U_IRQ, '0);
    endtask

    task automatic engine_launch();
        if (!p_active) begin
            p_active = 1; p_delay = '0;
        end
    endtask

    // runs one micro-instruction; returns 1 when the next may follow at once
    function automatic bit engine_exec(input logic sda, input logic scl);
        logic [27:0] w;
        if (p_ip >= CODE_DEPTH) begin
            p_fault = 1; p_active = 0; return 0;
        end
        if (p_ip >= p_count) begin
            p_active = 0; return 0;
        end
        w = p_code[p_ip];
        p_ip++;
        case (t_uop'(w[27:24]))
            U_SDA_LOW: p_drive[0] = 1'b1;
            U_SDA_REL: p_drive[0] = 1'b0;
            U_SCL_LOW: p_drive[1] = 1'b1;
            U_SCL_REL: p_drive[1] = 1'b0;
            U_ARB: if (!sda) begin
                p_i2sr[SR_IAL] = 1; p_mode = M_IDLE; p_active = 0; return 0;
            end
            U_WAIT: begin
                p_delay = w[23:0]; return 0;
            end
            U_SYNC: if (!scl) begin
                p_stretch = 1; p_stretch_cnt = '0; return 0;
            end
            U_END: begin
                p_active = 0; return 0;
            end
            U_IRQ: begin
                p_i2sr[SR_IIF] = 1; p_active = 0; return 0;
            end
            U_ACKCHK: begin
                if (!p_ack) begin
                    p_i2sr[SR_RXAK] = 1; p_active = 0; return 0;
                end
                p_i2sr[SR_RXAK] = 0;
            end
            U_BIT:    p_rx = {p_rx[6:0], sda};
            U_ACKIN:  p_ack = !sda;
            U_RXDONE: p_i2dr = p_rx;
            U_BUSFREE: if (p_i2sr[SR_IBB]) begin
                p_busfree_wait = 1; return 0;
            end
            default: begin
                p_fault = 1; p_active = 0; return 0;
            end
        endcase
        return 1;
    endfunction

    task automatic predict_reset();
        t_hold_start = 24'd4000; t_clock_low = 24'd4700; t_clock_high = 24'd4000;
        t_data_hold = 24'd1725; t_stop_setup = 24'd4000; t_bus_free = 24'd4700;
        t_timeout = 32'd200000000;
        p_iadr = '0; p_ifdr = '0; p_i2cr = '0; p_i2sr = '0; p_i2dr = '0;
        p_mode = M_IDLE;
        engine_clear();
        p_sda_prev = 1; p_drive = '0;
    endtask

    // register access part of one transaction
    task automatic bus_access(input t_in_item it, output logic [7:0] rd);
        logic [7:0] diff, v;
        rd = '0;
        v = it.write_data;
        if (it.operation == OP_READ) begin
            case (it.reg_select)
                REG_IADR: rd = p_iadr;
                REG_IFDR: rd = {2'b00, p_ifdr};
                REG_I2CR: rd = p_i2cr;
                REG_I2SR: rd = p_i2sr;
                REG_I2DR: begin
                    rd = p_i2dr;
                    if (p_mode == M_READ) begin
                        engine_clear();
                        emit_pulse(p_i2cr[CR_TXAK] ? U_SDA_REL : U_SDA_LOW,
                                   p_i2cr[CR_TXAK] ? U_ARB : U_NONE);
                        emit_receive();
                        engine_launch();
                    end
                end
                default: rd = '0;
            endcase
        end else if (it.operation == OP_WRITE) begin
            case (it.reg_select)
                REG_IADR: p_iadr = v & IADR_MASK;
                REG_IFDR: p_ifdr = v[5:0] & IFDR_MASK;
                REG_I2CR: begin
                    diff = v ^ p_i2cr;
                    if (p_i2cr[CR_IEN]) begin
                        if (diff[CR_MSTA] && v[CR_MSTA]) begin
                            engine_clear();
                            emit_start();
                        end else if (diff[CR_MSTA] && !v[CR_MSTA]) begin
                            engine_clear();
                            emit_stop();
                            engine_launch();
                            p_mode = M_IDLE;
                        end
                    end
                    p_i2cr = v & CTRL_STORE_MASK;
                end
                REG_I2SR: p_i2sr = p_i2sr & ~(~v & SR_W0C_MASK);
                REG_I2DR: begin
                    if (p_i2cr[CR_MSTA] && p_mode == M_IDLE) begin
                        emit_send(v);
                        if (v[0]) begin
                            p_mode = M_READ; emit_receive();
                        end else begin
                            p_mode = M_WRITE;
                        end
                        engine_launch();
                    end else if (p_mode == M_WRITE) begin
                        engine_clear();
                        emit_send(v);
                        engine_launch();
                    end
                end
                default: ;
            endcase
        end
    endtask

    // full step of the controller for one accepted transaction
    task automatic predict_step(input t_in_item it);
        logic       is_tick;
        logic [7:0] rd;
        t_out_item  res;
        is_tick = (it.operation == OP_TICK);
        if (is_tick && p_delay != 0) p_delay--;
        // bus monitor: SDA transitions while SCL is high
        if (it.scl_in && it.sda_in != p_sda_prev) begin
            if (!it.sda_in) begin
                p_i2sr[SR_IBB] = 1;
            end else begin
                p_i2sr[SR_IBB] = 0;
                if (p_busfree_wait) begin
                    p_busfree_wait = 0; p_delay = t_bus_free;
                end
            end
        end
        // clock stretch with time-out
        if (p_stretch) begin
            if (it.scl_in) begin
                p_stretch = 0;
            end else if (is_tick) begin
                if (p_stretch_cnt != 32'hffff_ffff) p_stretch_cnt++;
                if (p_stretch_cnt >= t_timeout) begin
                    p_stretch = 0; p_active = 0;
                end
            end
        end
        bus_access(it, rd);
        for (int n = 0; n <= CODE_DEPTH; n++) begin
            if (!p_active || p_delay != 0 || p_stretch || p_busfree_wait) break;
            if (!engine_exec(it.sda_in, it.scl_in)) break;
        end
        p_sda_prev = it.sda_in;
        res.read_data     = rd;
        res.sda_drive_low = p_drive[0];
        res.scl_drive_low = p_drive[1];
        res.irq_n         = !p_i2sr[SR_IIF];
        res.engine_fault  = p_fault;
        expected_q.push_back(res);
    endtask

    // ---------------------------------------------------------------
    // Sender: one transaction at a time, bursts with random gaps
    // ---------------------------------------------------------------
    int burst_left = 0;

    // valid drops at the negedge after acceptance, so the next transaction
    // goes out at a later negedge, never at that one
    task automatic send_item(input t_in_item it);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = $urandom_range(1, 30);
        end else begin
            @(negedge i_clk);
        end
        burst_left--;
        i_in       <= it;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_step(it);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // sender helpers; the SDA/SCL levels follow the modelled bus
    task automatic do_tick();
        t_in_item it;
        it = '0;
        it.operation = OP_TICK;
        it.reg_select = 3'($urandom_range(0, 7));
        it.write_data = 8'($urandom);
        it.sda_in = 1'(bus_sda);
        it.scl_in = 1'(bus_scl);
        send_item(it);
    endtask

    task automatic do_access(input logic [1:0] op, input logic [2:0] sel,
                             input logic [7:0] wd);
        t_in_item it;
        it.operation = op;
        it.reg_select = sel;
        it.write_data = wd;
        it.sda_in = 1'(bus_sda);
        it.scl_in = 1'(bus_scl);
        send_item(it);
    endtask

    task automatic wait_drained();
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_HOLD_START: t_hold_start = val[23:0];
            CFG_CLOCK_LOW:  t_clock_low  = val[23:0];
            CFG_CLOCK_HIGH: t_clock_high = val[23:0];
            CFG_DATA_HOLD:  t_data_hold  = val[23:0];
            CFG_STOP_SETUP: t_stop_setup = val[23:0];
            CFG_BUS_FREE:   t_bus_free   = val[23:0];
            CFG_TIMEOUT:    t_timeout    = val;
            default: ;
        endcase
    endtask

    // short timing so scripts finish within a handful of ticks
    task automatic cfg_fast(input int hi);
        write_cfg(CFG_HOLD_START, $urandom_range(0, hi));
        write_cfg(CFG_CLOCK_LOW,  $urandom_range(0, hi));
        write_cfg(CFG_CLOCK_HIGH, $urandom_range(0, hi));
        write_cfg(CFG_DATA_HOLD,  $urandom_range(0, hi));
        write_cfg(CFG_STOP_SETUP, $urandom_range(0, hi));
        write_cfg(CFG_BUS_FREE,   $urandom_range(0, hi));
        write_cfg(CFG_TIMEOUT,    $urandom_range(0, 6));
    endtask

    // bus line follows the drive, with random arbitration/ACK noise
    task automatic follow_bus(input int noise);
        bus_sda = (p_drive[0] || ($urandom_range(0, 99) < noise)) ? 0 : 1;
        bus_scl = (p_drive[1] || ($urandom_range(0, 99) < noise)) ? 0 : 1;
    endtask

    task automatic run_ticks(input int n, input int noise);
        repeat (n) begin
            follow_bus(noise);
            do_tick();
        end
    endtask

    // ---------------------------------------------------------------
    // Test tasks
    // ---------------------------------------------------------------
    task automatic test_registers();
        do_access(OP_WRITE, REG_IADR, 8'hff);
        do_access(OP_WRITE, REG_IFDR, 8'hff);
        do_access(OP_WRITE, REG_I2SR, 8'h00);
        do_access(OP_WRITE, 3'd7, 8'hff);
        for (int s = 0; s < 8; s++) do_access(OP_READ, 3'(s), 8'h00);
        do_access(OP_WRITE, REG_IADR, 8'h00);
        do_access(2'd3, REG_I2CR, 8'hff);              // no access, no tick
        do_access(OP_WRITE, REG_I2CR, 8'h7f);          // IEN clear: stored only
        do_access(OP_WRITE, REG_I2DR, 8'h55);          // MSTA set, idle, IEN clear
        wait_drained();
    endtask

    // one transfer: enable, start, address, bytes, stop
    task automatic transfer(input int noise);
        logic [7:0] addr;
        addr = 8'($urandom);
        do_access(OP_WRITE, REG_I2CR, 8'h80 | ($urandom_range(0, 1) ? 8'h08 : 8'h00));
        do_access(OP_WRITE, REG_I2CR, 8'ha0 | ($urandom_range(0, 1) ? 8'h08 : 8'h00));
        do_access(OP_WRITE, REG_I2DR, addr);
        run_ticks($urandom_range(20, 80), noise);
        repeat ($urandom_range(0, 3)) begin
            if (p_mode == M_READ) do_access(OP_READ, REG_I2DR, 8'h00);
            else do_access(OP_WRITE, REG_I2DR, 8'($urandom));
            run_ticks($urandom_range(20, 80), noise);
        end
        if ($urandom_range(0, 3) == 0) begin              // stop, then a new start
            do_access(OP_WRITE, REG_I2CR, 8'h80);
            do_access(OP_WRITE, REG_I2CR, 8'ha0);
            do_access(OP_WRITE, REG_I2DR, 8'($urandom));
            run_ticks($urandom_range(10, 40), noise);
        end
        do_access(OP_READ, REG_I2SR, 8'h00);
        do_access(OP_WRITE, REG_I2SR, 8'($urandom));
        do_access(OP_WRITE, REG_I2CR, 8'h80);           // stop
        run_ticks($urandom_range(10, 30), noise);
    endtask

    task automatic test_directed_transfer();
        cfg_fast(0);
        bus_sda = 1; bus_scl = 1;
        transfer(0);
        wait_drained();
    endtask

    task automatic test_random_transfers(input int target);
        int start_count;
        start_count = sent;
        while (sent - start_count < target) begin
            if ($urandom_range(0, 9) < 8) begin
                transfer($urandom_range(0, 20));
            end else begin
                do_access(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                          8'($urandom));
                bus_sda = $urandom_range(0, 1); bus_scl = $urandom_range(0, 1);
                do_tick();
            end
        end
        wait_drained();
    endtask

    // receiver holds off for a counted stretch while the sender keeps offering
    task automatic test_backpressure();
        hold_cycles = 150;
        run_ticks(40, 0);
        wait_drained();
    endtask

    // ---------------------------------------------------------------
    // Receiver: stall pattern and checker
    // ---------------------------------------------------------------
    always @(posedge i_clk) if (i_in_valid && o_in_ready) sent <= sent + 1;

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_ready <= 1'b0;
        end else begin
            stall_phase <= stall_phase + 1;
            if (stall_phase[8]) i_out_ready <= 1'b1;      // long stretch without stalls
            else i_out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", o_out);
            end else begin
                exp_item = expected_q.pop_front();
                if (o_out.read_data !== exp_item.read_data
                        || o_out.sda_drive_low !== exp_item.sda_drive_low
                        || o_out.scl_drive_low !== exp_item.scl_drive_low
                        || o_out.irq_n !== exp_item.irq_n
                        || o_out.engine_fault !== exp_item.engine_fault) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", exp_item, o_out);
                end
            end
        end
    end

    initial begin
        #40000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        predict_reset();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_registers();
        test_directed_transfer();
        test_backpressure();
        cfg_fast(3);
        test_random_transfers(500);
        write_cfg(CFG_HOLD_START, 32'hff_ffff);
        write_cfg(CFG_CLOCK_LOW, 32'hff_ffff);
        write_cfg(CFG_TIMEOUT, 32'hffff_ffff);
        test_random_transfers(100);
        cfg_fast(0);
        test_random_transfers(450);
        cfg_fast(8);
        test_random_transfers(250);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
